/* rtl/core/tfb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfb_pkg: shared types and constants of the telemetry frame builder.
// Holds the transfer payload types, the controller command and status types,
// the frame constants and the frame geometry helpers.
// ----------------------------------------------------------------------------
package tfb_pkg;

  localparam int FRAC_BITS = 8;
  localparam int VALUE_W   = 24;
  localparam int WORD_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int IDX_W     = 5;
  localparam int KIND_W    = 2;
  localparam int NUM_WORDS = 6;
  localparam int WSEL_W    = 3;
  localparam int PROD_W    = 32;
  localparam int MUL_W     = 8;

  localparam logic [KIND_W-1:0] KIND_ANGLE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCGYR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MOTOR  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'hAA;
  localparam logic [BYTE_W-1:0] ID_ANGLE  = 8'h01;
  localparam logic [BYTE_W-1:0] ID_ACCGYR = 8'h02;
  localparam logic [BYTE_W-1:0] ID_MOTOR  = 8'h06;
  localparam logic [BYTE_W-1:0] END_MARK  = 8'hA1;

  localparam logic [BYTE_W-1:0] LEN_ANGLE  = 8'd13;
  localparam logic [BYTE_W-1:0] LEN_ACCGYR = 8'd18;
  localparam logic [BYTE_W-1:0] LEN_MOTOR  = 8'd16;

  localparam logic [IDX_W-1:0] LAST_ANGLE  = 5'd17;
  localparam logic [IDX_W-1:0] LAST_ACCGYR = 5'd22;
  localparam logic [IDX_W-1:0] LAST_MOTOR  = 5'd20;
  localparam logic [IDX_W-1:0] END_IDX     = 5'd16;
  localparam logic [IDX_W-1:0] FIRST_WORD  = 5'd4;

  localparam logic [IDX_W-1:0] IDX_HDR0 = 5'd0;
  localparam logic [IDX_W-1:0] IDX_HDR1 = 5'd1;
  localparam logic [IDX_W-1:0] IDX_ID   = 5'd2;
  localparam logic [IDX_W-1:0] IDX_LEN  = 5'd3;

  localparam logic [WSEL_W-1:0] HEIGHT_WORD = 3'd3;
  localparam logic [WSEL_W-1:0] LAST_CONV   = 3'(NUM_WORDS - 1);

  localparam logic signed [MUL_W-1:0] SCALE    = 8'sd100;
  localparam logic signed [MUL_W-1:0] UNITY    = 8'sd1;
  localparam logic [WORD_W-1:0]       MOTOR_OFS = 16'd1000;

  localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);

  typedef struct packed {
    logic [KIND_W-1:0]         cmd;
    logic signed [VALUE_W-1:0] value0;
    logic signed [VALUE_W-1:0] value1;
    logic signed [VALUE_W-1:0] value2;
    logic signed [VALUE_W-1:0] value3;
    logic signed [VALUE_W-1:0] value4;
    logic signed [VALUE_W-1:0] value5;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              last_byte;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic              conv_en;
    logic [WSEL_W-1:0] conv_idx;
    logic              load;
    logic [IDX_W-1:0]  byte_idx;
    logic              last;
    logic [KIND_W-1:0] kind;
  } tfb_cmd_t;

  typedef struct packed {
    logic obuf_free;
  } tfb_status_t;

  function automatic logic [IDX_W-1:0] frame_last_idx(input logic [KIND_W-1:0] kind);
    logic [IDX_W-1:0] res;
    case (kind)
      KIND_ANGLE:  res = LAST_ANGLE;
      KIND_ACCGYR: res = LAST_ACCGYR;
      default:     res = LAST_MOTOR;
    endcase
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] frame_words_end(input logic [KIND_W-1:0] kind);
    logic [IDX_W-1:0] res;
    case (kind)
      KIND_ACCGYR: res = FIRST_WORD + 5'd12;
      default:     res = FIRST_WORD + 5'd8;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/telemetry_frame_builder_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// telemetry_frame_builder_unit: serialises telemetry requests into byte frames.
// A request transfer moves the sequencer to emit, where it loads the first byte.
// Throughput: one byte per cycle unless out_ready stalls the single registered
// byte output; a frame is 18, 21 or 23 bytes long (angle, motor, accel/gyro).
// The next request is taken in the cycle that loads the checksum byte.
// Reset (rst_n low, synchronous) returns the sequencer to idle and clears
// the checksum and the output valid.
// ----------------------------------------------------------------------------
module telemetry_frame_builder_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tfb_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tfb_pkg::out_item_t      out_item
);

  tfb_pkg::tfb_cmd_t    cmd;
  tfb_pkg::tfb_status_t status;

  tfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_item.cmd),
    .status   (status),
    .cmd      (cmd)
  );

  tfb_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_start_not_converting: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !cmd.conv_en)
    else $error("New frame started while words were still being converted.");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> status.obuf_free)
    else $error("Output stage overwritten before its transfer.");

  a_start_converts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> cmd.conv_en && (cmd.conv_idx == '0))
    else $error("Accepted request did not begin word conversion.");
`endif

endmodule
`default_nettype wire

/* rtl/core/tfb_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfb_ctrl: frame sequencing controller.
// Accepts requests, steps the word conversion counter and the byte counter,
// and issues load commands in the emit state while the datapath output is free.
// ----------------------------------------------------------------------------
module tfb_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [tfb_pkg::KIND_W-1:0] in_cmd,
  input  wire tfb_pkg::tfb_status_t       status,
  output tfb_pkg::tfb_cmd_t               cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                       state_r, state_nxt;
  logic [tfb_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [tfb_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [tfb_pkg::WSEL_W-1:0] conv_idx_r, conv_idx_nxt;
  logic                       conv_busy_r, conv_busy_nxt;
  logic                       at_last;
  logic                       load;
  logic                       start;

  assign at_last = (idx_r == tfb_pkg::frame_last_idx(kind_r));
  assign load    = (state_r == ST_EMIT) && status.obuf_free;
  assign in_ready = (state_r == ST_IDLE) || (load && at_last);
  assign start   = in_valid && in_ready && (in_cmd != tfb_pkg::KIND_NONE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    kind_nxt  = kind_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EMIT;
          idx_nxt   = '0;
          kind_nxt  = in_cmd;
        end
      end
      ST_EMIT: begin
        if (load) begin
          if (at_last) begin
            idx_nxt = '0;
            if (start) begin
              kind_nxt = in_cmd;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    conv_busy_nxt = conv_busy_r;
    conv_idx_nxt  = conv_idx_r;
    if (start) begin
      conv_busy_nxt = 1'b1;
      conv_idx_nxt  = '0;
    end else if (conv_busy_r) begin
      if (conv_idx_r == tfb_pkg::LAST_CONV) begin
        conv_busy_nxt = 1'b0;
      end else begin
        conv_idx_nxt = conv_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      kind_r      <= tfb_pkg::KIND_ANGLE;
      conv_idx_r  <= '0;
      conv_busy_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      kind_r      <= kind_nxt;
      conv_idx_r  <= conv_idx_nxt;
      conv_busy_r <= conv_busy_nxt;
    end
  end

  always_comb begin
    cmd.start    = start;
    cmd.conv_en  = conv_busy_r;
    cmd.conv_idx = conv_idx_r;
    cmd.load     = load;
    cmd.byte_idx = idx_r;
    cmd.last     = at_last;
    cmd.kind     = kind_r;
  end

endmodule
`default_nettype wire

/* rtl/core/tfb_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfb_datapath: word conversion, payload store, byte selection and checksum.
// Converts one payload word per cycle by a shared multiplier or motor offset,
// and feeds the selected frame byte into a registered output stage.
// ----------------------------------------------------------------------------
module tfb_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tfb_pkg::in_item_t   in_item,
  input  wire tfb_pkg::tfb_cmd_t   cmd,
  output tfb_pkg::tfb_status_t     status,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tfb_pkg::out_item_t       out_item
);

  tfb_pkg::in_item_t                 item_r;
  logic [tfb_pkg::WORD_W-1:0]        words_r [tfb_pkg::NUM_WORDS];
  logic [tfb_pkg::BYTE_W-1:0]        sum_r, sum_nxt;
  logic                              out_valid_r, out_valid_nxt;
  tfb_pkg::out_item_t                out_item_r;

  logic signed [tfb_pkg::VALUE_W-1:0] conv_raw;
  logic signed [tfb_pkg::MUL_W-1:0]   conv_mul;
  logic signed [tfb_pkg::PROD_W-1:0]  prod;
  logic signed [tfb_pkg::PROD_W-1:0]  quot;
  logic [tfb_pkg::WORD_W-1:0]         conv_word;

  logic [tfb_pkg::IDX_W-1:0]  w_off;
  logic [tfb_pkg::WSEL_W-1:0] w_sel;
  logic [tfb_pkg::WORD_W-1:0] w_data;
  logic [tfb_pkg::BYTE_W-1:0] byte_val;
  logic [tfb_pkg::BYTE_W-1:0] emit_byte;

  always_comb begin
    case (cmd.conv_idx)
      3'd0:    conv_raw = item_r.value0;
      3'd1:    conv_raw = item_r.value1;
      3'd2:    conv_raw = item_r.value2;
      3'd3:    conv_raw = item_r.value3;
      3'd4:    conv_raw = item_r.value4;
      3'd5:    conv_raw = item_r.value5;
      default: conv_raw = '0;
    endcase
  end

  assign conv_mul = ((cmd.kind == tfb_pkg::KIND_ANGLE) && (cmd.conv_idx == tfb_pkg::HEIGHT_WORD))
                    ? tfb_pkg::UNITY : tfb_pkg::SCALE;
  assign prod = tfb_pkg::PROD_W'(conv_raw) * tfb_pkg::PROD_W'(conv_mul);
  assign quot = (prod + (prod[tfb_pkg::PROD_W-1] ? tfb_pkg::TRUNC_BIAS : '0))
                >>> tfb_pkg::FRAC_BITS;

  always_comb begin
    if (cmd.kind == tfb_pkg::KIND_MOTOR) begin
      conv_word = conv_raw[tfb_pkg::WORD_W-1:0] - tfb_pkg::MOTOR_OFS;
    end else begin
      conv_word = quot[tfb_pkg::WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_r <= in_item;
    end
    if (cmd.conv_en) begin
      words_r[cmd.conv_idx] <= conv_word;
    end
  end

  assign w_off  = cmd.byte_idx - tfb_pkg::FIRST_WORD;
  assign w_sel  = w_off[tfb_pkg::WSEL_W:1];
  assign w_data = words_r[w_sel];

  always_comb begin
    case (cmd.byte_idx)
      tfb_pkg::IDX_HDR0,
      tfb_pkg::IDX_HDR1: byte_val = tfb_pkg::HDR_BYTE;
      tfb_pkg::IDX_ID: begin
        case (cmd.kind)
          tfb_pkg::KIND_ANGLE:  byte_val = tfb_pkg::ID_ANGLE;
          tfb_pkg::KIND_ACCGYR: byte_val = tfb_pkg::ID_ACCGYR;
          default:              byte_val = tfb_pkg::ID_MOTOR;
        endcase
      end
      tfb_pkg::IDX_LEN: begin
        case (cmd.kind)
          tfb_pkg::KIND_ANGLE:  byte_val = tfb_pkg::LEN_ANGLE;
          tfb_pkg::KIND_ACCGYR: byte_val = tfb_pkg::LEN_ACCGYR;
          default:              byte_val = tfb_pkg::LEN_MOTOR;
        endcase
      end
      default: begin
        if (cmd.byte_idx < tfb_pkg::frame_words_end(cmd.kind)) begin
          byte_val = w_off[0] ? w_data[tfb_pkg::BYTE_W-1:0]
                              : w_data[tfb_pkg::WORD_W-1:tfb_pkg::BYTE_W];
        end else if ((cmd.kind == tfb_pkg::KIND_ANGLE) &&
                     (cmd.byte_idx == tfb_pkg::END_IDX)) begin
          byte_val = tfb_pkg::END_MARK;
        end else begin
          byte_val = '0;
        end
      end
    endcase
  end

  assign emit_byte = cmd.last ? sum_r : byte_val;

  always_comb begin
    sum_nxt = sum_r;
    if (cmd.load) begin
      sum_nxt = cmd.last ? '0 : (sum_r + byte_val);
    end
  end

  assign status.obuf_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_item_r.frame_byte <= emit_byte;
      out_item_r.last_byte  <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire
